### rtl/core/rvcx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rvcx_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSED_EN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOAT_EN      = 1'd1;

  // Quadrants (bits 1:0 of the word).
  localparam logic [1:0] QUAD_0    = 2'b00;
  localparam logic [1:0] QUAD_1    = 2'b01;
  localparam logic [1:0] QUAD_2    = 2'b10;
  localparam logic [1:0] QUAD_FULL = 2'b11;

  // Base opcodes.
  localparam logic [6:0] OPC_LOAD     = 7'h03;
  localparam logic [6:0] OPC_LOAD_FP  = 7'h07;
  localparam logic [6:0] OPC_OP_IMM   = 7'h13;
  localparam logic [6:0] OPC_STORE    = 7'h23;
  localparam logic [6:0] OPC_STORE_FP = 7'h27;
  localparam logic [6:0] OPC_OP       = 7'h33;
  localparam logic [6:0] OPC_LUI      = 7'h37;
  localparam logic [6:0] OPC_BRANCH   = 7'h63;
  localparam logic [6:0] OPC_JALR     = 7'h67;
  localparam logic [6:0] OPC_JAL      = 7'h6f;

  localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;

  // Base funct3 and funct7 values.
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_WORD = 3'd2;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // Fixed registers.
  localparam logic [4:0] REG_X0 = 5'd0;
  localparam logic [4:0] REG_RA = 5'd1;
  localparam logic [4:0] REG_SP = 5'd2;

  // Quadrant 0 funct3.
  localparam logic [2:0] C0_ADDI4SPN = 3'd0;
  localparam logic [2:0] C0_LW       = 3'd2;
  localparam logic [2:0] C0_FLW      = 3'd3;
  localparam logic [2:0] C0_SW       = 3'd6;
  localparam logic [2:0] C0_FSW      = 3'd7;

  // Quadrant 1 funct3 and sub-codes.
  localparam logic [2:0] C1_ADDI = 3'd0;
  localparam logic [2:0] C1_JAL  = 3'd1;
  localparam logic [2:0] C1_LI   = 3'd2;
  localparam logic [2:0] C1_LUI  = 3'd3;
  localparam logic [2:0] C1_ALU  = 3'd4;
  localparam logic [2:0] C1_J    = 3'd5;
  localparam logic [2:0] C1_BEQZ = 3'd6;
  localparam logic [2:0] C1_BNEZ = 3'd7;

  localparam logic [1:0] C1_SRLI  = 2'd0;
  localparam logic [1:0] C1_SRAI  = 2'd1;
  localparam logic [1:0] C1_ANDI  = 2'd2;
  localparam logic [1:0] C1_ARITH = 2'd3;

  localparam logic [1:0] C1_OP_SUB = 2'd0;
  localparam logic [1:0] C1_OP_XOR = 2'd1;
  localparam logic [1:0] C1_OP_OR  = 2'd2;
  localparam logic [1:0] C1_OP_AND = 2'd3;

  // Quadrant 2 funct3.
  localparam logic [2:0] C2_SLLI  = 3'd0;
  localparam logic [2:0] C2_LWSP  = 3'd2;
  localparam logic [2:0] C2_FLWSP = 3'd3;
  localparam logic [2:0] C2_MISC  = 3'd4;
  localparam logic [2:0] C2_SWSP  = 3'd6;
  localparam logic [2:0] C2_FSWSP = 3'd7;

  typedef struct packed {
    logic compressed_enable;
    logic float_enable;
  } rvcx_cfg_t;

  typedef struct packed {
    logic [31:0] word;
    logic        illegal;
  } rvcx_res_t;

endpackage

`default_nettype wire

### rtl/core/rvcx_expand.sv
`timescale 1ns / 1ps
`default_nettype none

module rvcx_expand (
  input  wire logic [31:0]       word_i,
  input  wire rvcx_pkg::rvcx_cfg_t cfg_i,
  output rvcx_pkg::rvcx_res_t    res_o
);

  function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                        input logic [2:0] f3, input logic [4:0] rd,
                                        input logic [6:0] op);
    enc_i = {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3,
                                        input logic [4:0] rd);
    enc_r = {f7, rs2, rs1, f3, rd, rvcx_pkg::OPC_OP};
  endfunction

  function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [6:0] op);
    enc_s = {imm[11:5], rs2, rs1, rvcx_pkg::F3_WORD, imm[4:0], op};
  endfunction

  logic [15:0] c;
  logic [2:0]  f3;
  logic        b12;
  logic [4:0]  rd;
  logic [4:0]  rs2;
  logic [4:0]  rp1;
  logic [4:0]  rp2;
  logic [11:0] imm6;
  logic [9:0]  nzuimm;
  logic [11:0] moff;
  logic [11:0] loff;
  logic [11:0] soff;
  logic [20:0] jimm;
  logic [12:0] bimm;
  logic [9:0]  spimm;
  logic [31:0] exp_word;
  logic        ok;

  assign c      = word_i[15:0];
  assign f3     = c[15:13];
  assign b12    = c[12];
  assign rd     = c[11:7];
  assign rs2    = c[6:2];
  assign rp1    = {2'b01, c[9:7]};
  assign rp2    = {2'b01, c[4:2]};
  assign imm6   = {{7{c[12]}}, c[6:2]};
  assign nzuimm = {c[10:7], c[12:11], c[5], c[6], 2'b00};
  assign moff   = {5'd0, c[5], c[12:10], c[6], 2'b00};
  assign loff   = {4'd0, c[3:2], c[12], c[6:4], 2'b00};
  assign soff   = {4'd0, c[8:7], c[12:9], 2'b00};
  assign jimm   = {{10{c[12]}}, c[8], c[10:9], c[6], c[7], c[2], c[11], c[5:3], 1'b0};
  assign bimm   = {{5{c[12]}}, c[6:5], c[2], c[11:10], c[4:3], 1'b0};
  assign spimm  = {c[12], c[4:3], c[5], c[2], c[6], 4'd0};

  always_comb begin
    exp_word = '0;
    ok       = 1'b0;
    unique case (word_i[1:0])
      rvcx_pkg::QUAD_FULL: begin
        exp_word = word_i;
        ok       = 1'b1;
      end
      rvcx_pkg::QUAD_0: begin
        unique case (f3)
          rvcx_pkg::C0_ADDI4SPN: begin
            exp_word = enc_i({2'b00, nzuimm}, rvcx_pkg::REG_SP, rvcx_pkg::F3_ADD, rp2,
                             rvcx_pkg::OPC_OP_IMM);
            ok = (nzuimm != 10'd0);
          end
          rvcx_pkg::C0_LW: begin
            exp_word = enc_i(moff, rp1, rvcx_pkg::F3_WORD, rp2, rvcx_pkg::OPC_LOAD);
            ok = 1'b1;
          end
          rvcx_pkg::C0_FLW: begin
            exp_word = enc_i(moff, rp1, rvcx_pkg::F3_WORD, rp2, rvcx_pkg::OPC_LOAD_FP);
            ok = cfg_i.float_enable;
          end
          rvcx_pkg::C0_SW: begin
            exp_word = enc_s(moff, rp2, rp1, rvcx_pkg::OPC_STORE);
            ok = 1'b1;
          end
          rvcx_pkg::C0_FSW: begin
            exp_word = enc_s(moff, rp2, rp1, rvcx_pkg::OPC_STORE_FP);
            ok = cfg_i.float_enable;
          end
          default: ok = 1'b0;
        endcase
      end
      rvcx_pkg::QUAD_1: begin
        unique case (f3)
          rvcx_pkg::C1_ADDI: begin
            exp_word = enc_i(imm6, rd, rvcx_pkg::F3_ADD, rd, rvcx_pkg::OPC_OP_IMM);
            ok = 1'b1;
          end
          rvcx_pkg::C1_JAL, rvcx_pkg::C1_J: begin
            exp_word = {jimm[20], jimm[10:1], jimm[11], jimm[19:12],
                        (f3 == rvcx_pkg::C1_JAL) ? rvcx_pkg::REG_RA : rvcx_pkg::REG_X0,
                        rvcx_pkg::OPC_JAL};
            ok = 1'b1;
          end
          rvcx_pkg::C1_LI: begin
            exp_word = enc_i(imm6, rvcx_pkg::REG_X0, rvcx_pkg::F3_ADD, rd,
                             rvcx_pkg::OPC_OP_IMM);
            ok = 1'b1;
          end
          rvcx_pkg::C1_LUI: begin
            if (rd == rvcx_pkg::REG_SP) begin
              exp_word = enc_i({{2{spimm[9]}}, spimm}, rvcx_pkg::REG_SP, rvcx_pkg::F3_ADD,
                               rvcx_pkg::REG_SP, rvcx_pkg::OPC_OP_IMM);
              ok = (spimm != 10'd0);
            end else begin
              exp_word = {{15{c[12]}}, c[6:2], rd, rvcx_pkg::OPC_LUI};
              ok = (imm6 != 12'd0);
            end
          end
          rvcx_pkg::C1_ALU: begin
            unique case (c[11:10])
              rvcx_pkg::C1_SRLI, rvcx_pkg::C1_SRAI: begin
                exp_word = enc_i({1'b0, c[10], 5'd0, c[6:2]}, rp1, rvcx_pkg::F3_SR, rp1,
                                 rvcx_pkg::OPC_OP_IMM);
                ok = !b12;
              end
              rvcx_pkg::C1_ANDI: begin
                exp_word = enc_i(imm6, rp1, rvcx_pkg::F3_AND, rp1, rvcx_pkg::OPC_OP_IMM);
                ok = 1'b1;
              end
              rvcx_pkg::C1_ARITH: begin
                ok = !b12;
                unique case (c[6:5])
                  rvcx_pkg::C1_OP_SUB:
                    exp_word = enc_r(rvcx_pkg::F7_ALT, rp2, rp1, rvcx_pkg::F3_ADD, rp1);
                  rvcx_pkg::C1_OP_XOR:
                    exp_word = enc_r(rvcx_pkg::F7_BASE, rp2, rp1, rvcx_pkg::F3_XOR, rp1);
                  rvcx_pkg::C1_OP_OR:
                    exp_word = enc_r(rvcx_pkg::F7_BASE, rp2, rp1, rvcx_pkg::F3_OR, rp1);
                  rvcx_pkg::C1_OP_AND:
                    exp_word = enc_r(rvcx_pkg::F7_BASE, rp2, rp1, rvcx_pkg::F3_AND, rp1);
                  default: exp_word = '0;
                endcase
              end
              default: ok = 1'b0;
            endcase
          end
          rvcx_pkg::C1_BEQZ, rvcx_pkg::C1_BNEZ: begin
            exp_word = {bimm[12], bimm[10:5], rvcx_pkg::REG_X0, rp1,
                        (f3 == rvcx_pkg::C1_BEQZ) ? rvcx_pkg::F3_BEQ : rvcx_pkg::F3_BNE,
                        bimm[4:1], bimm[11], rvcx_pkg::OPC_BRANCH};
            ok = 1'b1;
          end
          default: ok = 1'b0;
        endcase
      end
      rvcx_pkg::QUAD_2: begin
        unique case (f3)
          rvcx_pkg::C2_SLLI: begin
            exp_word = enc_i({7'd0, c[6:2]}, rd, rvcx_pkg::F3_SLL, rd, rvcx_pkg::OPC_OP_IMM);
            ok = !b12;
          end
          rvcx_pkg::C2_LWSP: begin
            exp_word = enc_i(loff, rvcx_pkg::REG_SP, rvcx_pkg::F3_WORD, rd, rvcx_pkg::OPC_LOAD);
            ok = (rd != rvcx_pkg::REG_X0);
          end
          rvcx_pkg::C2_FLWSP: begin
            exp_word = enc_i(loff, rvcx_pkg::REG_SP, rvcx_pkg::F3_WORD, rd,
                             rvcx_pkg::OPC_LOAD_FP);
            ok = cfg_i.float_enable;
          end
          rvcx_pkg::C2_MISC: begin
            ok = 1'b1;
            if (!b12) begin
              if (rs2 != rvcx_pkg::REG_X0) begin
                exp_word = enc_i(12'd0, rs2, rvcx_pkg::F3_ADD, rd, rvcx_pkg::OPC_OP_IMM);
              end else begin
                exp_word = enc_i(12'd0, rd, rvcx_pkg::F3_ADD, rvcx_pkg::REG_X0,
                                 rvcx_pkg::OPC_JALR);
                ok = (rd != rvcx_pkg::REG_X0);
              end
            end else if (rs2 == rvcx_pkg::REG_X0) begin
              if (rd == rvcx_pkg::REG_X0) begin
                exp_word = rvcx_pkg::EBREAK_WORD;
              end else begin
                exp_word = enc_i(12'd0, rd, rvcx_pkg::F3_ADD, rvcx_pkg::REG_RA,
                                 rvcx_pkg::OPC_JALR);
              end
            end else begin
              exp_word = enc_r(rvcx_pkg::F7_BASE, rs2, rd, rvcx_pkg::F3_ADD, rd);
            end
          end
          rvcx_pkg::C2_SWSP: begin
            exp_word = enc_s(soff, rs2, rvcx_pkg::REG_SP, rvcx_pkg::OPC_STORE);
            ok = 1'b1;
          end
          rvcx_pkg::C2_FSWSP: begin
            exp_word = enc_s(soff, rs2, rvcx_pkg::REG_SP, rvcx_pkg::OPC_STORE_FP);
            ok = cfg_i.float_enable;
          end
          default: ok = 1'b0;
        endcase
      end
      default: ok = 1'b0;
    endcase
    if (word_i[1:0] != rvcx_pkg::QUAD_FULL && !cfg_i.compressed_enable) begin
      ok = 1'b0;
    end
  end

  assign res_o.word    = ok ? exp_word : 32'd0;
  assign res_o.illegal = !ok;

endmodule

`default_nettype wire

### rtl/core/rvc_instruction_expander_core.sv
// Input words are registered in s1_word_r; results in out_word_r (out_tdata).
// Throughput: one word per cycle; the input register, the expansion logic and
// the output register form a two-stage pipeline that stalls only on out_tready.
// Reset (rst_n low, synchronous) empties both stages and sets compressed_enable
// and float_enable to 1.
`timescale 1ns / 1ps
`default_nettype none

module rvc_instruction_expander_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output      logic                           in_tready,
  input  wire logic [31:0]                    in_tdata,   // instruction_word
  output      logic                           out_tvalid,
  input  wire logic                           out_tready,
  output      logic [31:0]                    out_tdata,  // expanded_word
  output      logic                           out_tuser,  // illegal
  input  wire logic                           cfg_we,
  input  wire logic [rvcx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic                           cfg_wdata
);

  rvcx_pkg::rvcx_cfg_t cfg_r;
  logic                s1_valid_r;
  logic [31:0]         s1_word_r;
  logic                out_valid_r;
  logic [31:0]         out_word_r;
  logic                out_illegal_r;
  logic                s1_ready;
  logic                s1_fire;
  rvcx_pkg::rvcx_res_t exp_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.compressed_enable <= 1'b1;
      cfg_r.float_enable      <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rvcx_pkg::CFG_COMPRESSED_EN: cfg_r.compressed_enable <= cfg_wdata;
        rvcx_pkg::CFG_FLOAT_EN:      cfg_r.float_enable      <= cfg_wdata;
        default:                     cfg_r                   <= cfg_r;
      endcase
    end
  end

  assign s1_ready  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s1_ready;
  assign in_tready = !s1_valid_r || s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_word_r <= in_tdata;
    end
  end

  rvcx_expand u_expand (
    .word_i (s1_word_r),
    .cfg_i  (cfg_r),
    .res_o  (exp_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_word_r    <= exp_res.word;
      out_illegal_r <= exp_res.illegal;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_tuser  = out_illegal_r;

  a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == 32'd0))
    else $error("illegal result carries a nonzero word");

  a_full_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_word_r[1:0] == rvcx_pkg::QUAD_FULL)
      |=> (out_tdata == $past(s1_word_r) && !out_tuser))
    else $error("32-bit word not passed through unchanged");

  a_disabled_illegal: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !cfg_r.compressed_enable && s1_word_r[1:0] != rvcx_pkg::QUAD_FULL)
      |=> out_tuser)
    else $error("compressed word expanded while compression is disabled");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tvalid && in_tready && s1_valid_r && out_valid_r && !out_tready))
    else $error("input word accepted while the pipeline is full and stalled");

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rvcx_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_WORDS  = 84;
  localparam int unsigned LIMIT_NS     = 2_000_000;

  typedef struct packed {
    logic [31:0] word;
    logic        known;
    rvcx_res_t   result;
  } stim_row_t;

  localparam rvcx_res_t ILLEGAL_RES = '{word: 32'h0, illegal: 1'b1};
  localparam rvcx_res_t PREDICTED   = '{word: 32'h0, illegal: 1'b0};

  localparam int unsigned DIRECTED_ROWS = 45;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 1'b0}},
    '{32'h0000_0003, 1'b1, '{32'h0000_0003, 1'b0}},
    '{32'h0000_0000, 1'b1, ILLEGAL_RES},
    '{32'hFFFF_1FFC, 1'b0, PREDICTED},
    '{32'h0000_5FFC, 1'b0, PREDICTED},
    '{32'h0000_7FFC, 1'b0, PREDICTED},
    '{32'h0000_DFFC, 1'b0, PREDICTED},
    '{32'h0000_FFFC, 1'b0, PREDICTED},
    '{32'h0000_2000, 1'b1, ILLEGAL_RES},
    '{32'h0000_8000, 1'b1, ILLEGAL_RES},
    '{32'h0000_A000, 1'b1, ILLEGAL_RES},
    '{32'h0000_1FFD, 1'b0, PREDICTED},
    '{32'h0000_3FFD, 1'b0, PREDICTED},
    '{32'h0000_5FFD, 1'b0, PREDICTED},
    '{32'h0000_6101, 1'b1, ILLEGAL_RES},
    '{32'h0000_7101, 1'b0, PREDICTED},
    '{32'h0000_6081, 1'b1, ILLEGAL_RES},
    '{32'h0000_6005, 1'b0, PREDICTED},
    '{32'h0000_7FFD, 1'b0, PREDICTED},
    '{32'h0000_807D, 1'b0, PREDICTED},
    '{32'h0000_9401, 1'b1, ILLEGAL_RES},
    '{32'h0000_847D, 1'b0, PREDICTED},
    '{32'h0000_9BFD, 1'b0, PREDICTED},
    '{32'h0000_8C01, 1'b0, PREDICTED},
    '{32'h0000_8C21, 1'b0, PREDICTED},
    '{32'h0000_8C41, 1'b0, PREDICTED},
    '{32'h0000_8C7D, 1'b0, PREDICTED},
    '{32'h0000_9C01, 1'b1, ILLEGAL_RES},
    '{32'h0000_BFFD, 1'b0, PREDICTED},
    '{32'h0000_DFFD, 1'b0, PREDICTED},
    '{32'h0000_E001, 1'b0, PREDICTED},
    '{32'h0000_0FFE, 1'b0, PREDICTED},
    '{32'h0000_1002, 1'b1, ILLEGAL_RES},
    '{32'h0000_4002, 1'b1, ILLEGAL_RES},
    '{32'h0000_5FFE, 1'b0, PREDICTED},
    '{32'h0000_7FFE, 1'b0, PREDICTED},
    '{32'h0000_2002, 1'b1, ILLEGAL_RES},
    '{32'h0000_A002, 1'b1, ILLEGAL_RES},
    '{32'h0000_8002, 1'b1, ILLEGAL_RES},
    '{32'h0000_8082, 1'b0, PREDICTED},
    '{32'h0000_8FFE, 1'b0, PREDICTED},
    '{32'h0000_9002, 1'b1, '{EBREAK_WORD, 1'b0}},
    '{32'h0000_9F82, 1'b0, PREDICTED},
    '{32'h0000_9FFE, 1'b0, PREDICTED},
    '{32'h0000_FFFE, 1'b0, PREDICTED}
  };

  localparam int unsigned PHASES = 6;
  localparam rvcx_cfg_t PHASE_CFG [PHASES] = '{
    '{1'b1, 1'b1}, '{1'b1, 1'b0}, '{1'b0, 1'b1}, '{1'b1, 1'b1}, '{1'b0, 1'b0}, '{1'b1, 1'b1}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [31:0]          in_tdata;   // instruction_word
  logic                 out_tvalid;
  logic                 out_tready;
  logic [31:0]          out_tdata;  // expanded_word
  logic                 out_tuser;  // illegal
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic                 cfg_wdata;

  rvcx_cfg_t expander_cfg;
  rvcx_res_t pending_expansions[$];
  rvcx_res_t oldest_expansion;
  int        error_count = 0;
  logic      quiet = 1'b0;
  logic      hold_out = 1'b0;

  rvc_instruction_expander_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                        input logic [2:0] f3, input logic [4:0] rd,
                                        input logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [6:0] op);
    return {imm[11:5], rs2, rs1, F3_WORD, imm[4:0], op};
  endfunction

  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3,
                                        input logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OPC_OP};
  endfunction

  function automatic rvcx_res_t expand_word(input logic [31:0] w, input rvcx_cfg_t cfg);
    rvcx_res_t  res;
    logic [15:0] c;
    logic [2:0]  f3;
    logic        b12;
    logic [4:0]  rd, rs2, rp1, rp2;
    logic [31:0] imm6, r;
    logic [9:0]  t4spn, spof;
    logic [6:0]  moff;
    logic [7:0]  loff, soff;
    logic [11:0] jof;
    logic [8:0]  bof;
    logic        ok;
    c    = w[15:0];
    f3   = c[15:13];
    b12  = c[12];
    rd   = c[11:7];
    rs2  = c[6:2];
    rp1  = {2'b01, c[9:7]};
    rp2  = {2'b01, c[4:2]};
    imm6 = {{27{b12}}, c[6:2]};
    moff = {c[5], c[12:10], c[6], 2'b00};
    loff = {c[3:2], b12, c[6:4], 2'b00};
    soff = {c[8:7], c[12:9], 2'b00};
    t4spn = {c[10:7], c[12:11], c[5], c[6], 2'b00};
    spof = {b12, c[4:3], c[5], c[2], c[6], 4'b0000};
    jof  = {b12, c[8], c[10:9], c[6], c[7], c[2], c[11], c[5:3], 1'b0};
    bof  = {b12, c[6:5], c[2], c[11:10], c[4:3], 1'b0};
    r  = '0;
    ok = 1'b1;
    if (w[1:0] == QUAD_FULL) begin
      r = w;
    end else if (!cfg.compressed_enable) begin
      ok = 1'b0;
    end else begin
      case (w[1:0])
        QUAD_0: begin
          case (f3)
            C0_ADDI4SPN: begin
              if (t4spn == '0) ok = 1'b0;
              else r = enc_i({2'b00, t4spn}, REG_SP, F3_ADD, rp2, OPC_OP_IMM);
            end
            C0_LW:  r = enc_i({5'd0, moff}, rp1, F3_WORD, rp2, OPC_LOAD);
            C0_FLW: begin
              if (!cfg.float_enable) ok = 1'b0;
              else r = enc_i({5'd0, moff}, rp1, F3_WORD, rp2, OPC_LOAD_FP);
            end
            C0_SW:  r = enc_s({5'd0, moff}, rp2, rp1, OPC_STORE);
            C0_FSW: begin
              if (!cfg.float_enable) ok = 1'b0;
              else r = enc_s({5'd0, moff}, rp2, rp1, OPC_STORE_FP);
            end
            default: ok = 1'b0;
          endcase
        end
        QUAD_1: begin
          case (f3)
            C1_ADDI: r = enc_i(imm6[11:0], rd, F3_ADD, rd, OPC_OP_IMM);
            C1_JAL, C1_J: begin
              r = {b12, jof[10:1], b12, {8{b12}}, (f3 == C1_JAL) ? REG_RA : REG_X0, OPC_JAL};
            end
            C1_LI: r = enc_i(imm6[11:0], REG_X0, F3_ADD, rd, OPC_OP_IMM);
            C1_LUI: begin
              if (rd == REG_SP) begin
                if (spof == '0) ok = 1'b0;
                else r = enc_i({{2{b12}}, spof}, REG_SP, F3_ADD, REG_SP, OPC_OP_IMM);
              end else if (imm6 == '0) begin
                ok = 1'b0;
              end else begin
                r = {imm6[19:0], rd, OPC_LUI};
              end
            end
            C1_ALU: begin
              case (c[11:10])
                C1_SRLI, C1_SRAI: begin
                  if (b12) ok = 1'b0;
                  else r = enc_i({c[10] ? F7_ALT : F7_BASE, rs2}, rp1, F3_SR, rp1, OPC_OP_IMM);
                end
                C1_ANDI: r = enc_i(imm6[11:0], rp1, F3_AND, rp1, OPC_OP_IMM);
                default: begin
                  if (b12) begin
                    ok = 1'b0;
                  end else begin
                    case (c[6:5])
                      C1_OP_SUB: r = enc_r(F7_ALT, rp2, rp1, F3_ADD, rp1);
                      C1_OP_XOR: r = enc_r(F7_BASE, rp2, rp1, F3_XOR, rp1);
                      C1_OP_OR:  r = enc_r(F7_BASE, rp2, rp1, F3_OR, rp1);
                      default:   r = enc_r(F7_BASE, rp2, rp1, F3_AND, rp1);
                    endcase
                  end
                end
              endcase
            end
            default: begin
              r = {b12, {2{b12}}, bof[8:5], REG_X0, rp1,
                   (f3 == C1_BEQZ) ? F3_BEQ : F3_BNE, bof[4:1], b12, OPC_BRANCH};
            end
          endcase
        end
        QUAD_2: begin
          case (f3)
            C2_SLLI: begin
              if (b12) ok = 1'b0;
              else r = enc_i({7'd0, rs2}, rd, F3_SLL, rd, OPC_OP_IMM);
            end
            C2_LWSP: begin
              if (rd == REG_X0) ok = 1'b0;
              else r = enc_i({4'd0, loff}, REG_SP, F3_WORD, rd, OPC_LOAD);
            end
            C2_FLWSP: begin
              if (!cfg.float_enable) ok = 1'b0;
              else r = enc_i({4'd0, loff}, REG_SP, F3_WORD, rd, OPC_LOAD_FP);
            end
            C2_MISC: begin
              if (!b12) begin
                if (rs2 != REG_X0) r = enc_i(12'd0, rs2, F3_ADD, rd, OPC_OP_IMM);
                else if (rd == REG_X0) ok = 1'b0;
                else r = enc_i(12'd0, rd, F3_ADD, REG_X0, OPC_JALR);
              end else if (rs2 == REG_X0) begin
                r = (rd == REG_X0) ? EBREAK_WORD : enc_i(12'd0, rd, F3_ADD, REG_RA, OPC_JALR);
              end else begin
                r = enc_r(F7_BASE, rs2, rd, F3_ADD, rd);
              end
            end
            C2_SWSP: r = enc_s({4'd0, soff}, rs2, REG_SP, OPC_STORE);
            C2_FSWSP: begin
              if (!cfg.float_enable) ok = 1'b0;
              else r = enc_s({4'd0, soff}, rs2, REG_SP, OPC_STORE_FP);
            end
            default: ok = 1'b0;
          endcase
        end
        default: ok = 1'b0;
      endcase
    end
    res.word    = ok ? r : 32'h0;
    res.illegal = !ok;
    return res;
  endfunction

  task automatic send_word(input logic [31:0] w, input logic known, input rvcx_res_t known_res);
    while (!quiet && $urandom_range(99) < 16) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
    pending_expansions.push_back(known ? known_res : expand_word(w, expander_cfg));
  endtask

  // The sender stays quiet until every expected word has come back.
  task automatic drain_results;
    in_tvalid <= 1'b0;
    while (pending_expansions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(input rvcx_cfg_t next_cfg);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_COMPRESSED_EN;
    cfg_wdata <= next_cfg.compressed_enable;
    @(posedge clk);
    cfg_index <= CFG_FLOAT_EN;
    cfg_wdata <= next_cfg.float_enable;
    @(posedge clk);
    cfg_we <= 1'b0;
    expander_cfg = next_cfg;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end
      out_tready <= quiet || ($urandom_range(99) >= 16);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_expansions.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %h illegal %b",
                 $time, out_tdata, out_tuser);
        error_count++;
      end else begin
        oldest_expansion = pending_expansions.pop_front();
        if (out_tdata !== oldest_expansion.word) begin
          $display("%0t: expanded word mismatch, expected %h, got %h",
                   $time, oldest_expansion.word, out_tdata);
          error_count++;
        end
        if (out_tuser !== oldest_expansion.illegal) begin
          $display("%0t: illegal flag mismatch, expected %b, got %b",
                   $time, oldest_expansion.illegal, out_tuser);
          error_count++;
        end
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [31:0] w;
    int          phase;
    int          k;
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_COMPRESSED_EN;
    cfg_wdata    <= 1'b0;
    expander_cfg = '{1'b1, 1'b1};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < DIRECTED_ROWS; k++) begin
      send_word(DIRECTED[k].word, DIRECTED[k].known, DIRECTED[k].result);
    end
    drain_results();

    for (phase = 0; phase < PHASES; phase++) begin
      apply_config(PHASE_CFG[phase]);
      // The output stalls long enough for the pipeline to back up into the input.
      if (phase == 0) hold_out = 1'b1;
      for (k = 0; k < PHASE_WORDS; k++) begin
        quiet = (phase == 3) && (k < 60);
        w = $urandom;
        if ($urandom_range(3) != 0) begin
          w[1:0] = 2'($urandom_range(2));
          if ($urandom_range(3) == 0) w[6:2] = '0;
          if ($urandom_range(3) == 0) w[11:7] = '0;
          if ($urandom_range(7) == 0) w[12] = 1'b0;
        end
        send_word(w, 1'b0, PREDICTED);
      end
      quiet = 1'b0;
      drain_results();
    end

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/rvcx_pkg.sv
rtl/core/rvcx_expand.sv
rtl/core/rvc_instruction_expander_core.sv
sim/testbench.sv
